[rtl/core/dffc_pkg.sv]
// Shared constants, stage types and divider step for the dark/flat frame calibration block.
package dffc_pkg;

   // Pipeline shape: one front stage, one numerator stage, five divider stages.
   localparam int unsigned PIPE_DEPTH = 7;
   localparam int unsigned QUO_W      = 10;

   // Register indexes on the control port.
   localparam int unsigned CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FLAT_EN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_LUMA  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_U     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_V     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LUMA_FLOOR = 3'd5;
   localparam int unsigned CSR_DATA_W = 16;

   // Operating modes.
   localparam logic [1:0] MODE_CORRECT = 2'd0;
   localparam logic [1:0] MODE_DARK    = 2'd1;
   localparam logic [1:0] MODE_LIGHT   = 2'd2;
   localparam logic [1:0] MODE_FLAT    = 2'd3;

   // Plane codes; the unused code behaves as V.
   localparam logic [1:0] PLANE_LUMA  = 2'd0;
   localparam logic [1:0] PLANE_U     = 2'd1;
   localparam logic [1:0] PLANE_V     = 2'd2;
   localparam logic [1:0] PLANE_SPARE = 2'd3;

   localparam logic [15:0] CHROMA_MID_Q = 16'd32512;   // 127.0 in Q8.8
   localparam logic signed [17:0] BIAS_LIMIT = 18'sd16384; // 64.0 in Q8.8

   // Front stage: luma product plus a ready-made result for every other case.
   typedef struct packed {
      logic [23:0] prod;
      logic [7:0]  flat;
      logic [7:0]  bypass;
      logic        use_div;
   } front_type;

   // Divider stages: partial remainder and quotient.
   typedef struct packed {
      logic [16:0]      rem;
      logic [QUO_W-1:0] quo;
      logic [7:0]       flat;
      logic [7:0]       bypass;
      logic             use_div;
   } div_type;

   // Two restoring steps, quotient bits hi and hi-1.
   function automatic div_type div_pair(input div_type d, input logic [3:0] hi);
      div_type     r;
      logic [17:0] dsr;
      logic [3:0]  b;
      r = d;
      for (int j = 0; j < 2; j++) begin
         b   = hi - 4'(j);
         dsr = 18'(r.flat) << b;
         if ({1'b0, r.rem} >= dsr) begin
            r.rem   = 17'({1'b0, r.rem} - dsr);
            r.quo[b] = 1'b1;
         end
      end
      return r;
   endfunction

endpackage

[rtl/core/dark_flat_frame_calibration.sv]
// Top level: per-sample dark frame subtraction and flat field correction pipeline.
//   req_*  : one request per sample: plane tag, live sample and the dark, light and
//            flat calibration samples. Accepted when req_valid is high, req_stall low.
//   rsp_*  : one corrected byte per request, in request order. Taken when rsp_valid
//            is high and rsp_stall is low.
//   csr_*  : register writes (index, data); csr_ready is always high. Write only
//            while no request is in flight.
// With no stall, one request enters per cycle. The 7 stages: a front stage (dark
// subtraction, 8x16 luma product, all non-divide cases), a numerator stage, and a
// 10-bit restoring divider by the flat sample retiring two quotient bits in each of
// five stages.
// Each stage moves when the stage after it is empty or moving, so bubbles close up
// under rsp_stall and no request is lost or repeated. req_stall rises only when every
// stage holds a request and the output is stalled.
// Reset (synchronous, active high) empties the pipeline and restores the registers:
// mode 0, flat enable 1, means 0, luma floor 0. A zero luma mean passes the live
// sample through.
module dark_flat_frame_calibration (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_plane,
   input  logic [7:0]                          req_live_sample,
   input  logic [7:0]                          req_dark_sample,
   input  logic [7:0]                          req_light_sample,
   input  logic [7:0]                          req_flat_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [7:0]                          rsp_out_sample,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [dffc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [dffc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int unsigned LAST = dffc_pkg::PIPE_DEPTH - 1;

   // ---------------- control registers ----------------
   logic [1:0]  mode_ff;
   logic        flat_en_ff;
   logic [15:0] mean_luma_ff;
   logic [15:0] mean_u_ff;
   logic [15:0] mean_v_ff;
   logic [7:0]  luma_floor_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= dffc_pkg::MODE_CORRECT;
         flat_en_ff    <= 1'b1;
         mean_luma_ff  <= '0;
         mean_u_ff     <= '0;
         mean_v_ff     <= '0;
         luma_floor_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            dffc_pkg::CSR_MODE:       mode_ff       <= csr_wdata[1:0];
            dffc_pkg::CSR_FLAT_EN:    flat_en_ff    <= csr_wdata[0];
            dffc_pkg::CSR_MEAN_LUMA:  mean_luma_ff  <= csr_wdata;
            dffc_pkg::CSR_MEAN_U:     mean_u_ff     <= csr_wdata;
            dffc_pkg::CSR_MEAN_V:     mean_v_ff     <= csr_wdata;
            dffc_pkg::CSR_LUMA_FLOOR: luma_floor_ff <= csr_wdata[7:0];
            default: ;                // unmapped index: ignored
         endcase
      end
   end

   // ---------------- flow control ----------------
   logic [LAST:0] valid_ff;
   logic [LAST:0] valid_in;
   logic [LAST:0] adv;

   always_comb begin
      adv[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 0; k--) begin
         adv[k] = !valid_ff[k] || adv[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k <= LAST; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[LAST];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k <= LAST; k++) begin
            if (adv[k]) valid_ff[k] <= valid_in[k];
         end
      end
   end

   // ---------------- front stage ----------------
   logic [8:0]         diff_ld;     // live - dark, bit 8 = negative
   logic [7:0]         s_pos;       // difference floored at zero
   logic signed [9:0]  cdiff;       // 127 + live - dark
   logic [15:0]        mean_c;
   logic [15:0]        m_c;
   logic signed [17:0] bias_raw;
   logic signed [17:0] bias_cl;
   logic signed [19:0] cv;
   logic signed [19:0] cr;
   logic [7:0]         chroma_flat_res;
   logic [7:0]         chroma_raw_res;
   logic [7:0]         luma_raw_res;
   logic [8:0]         sq;
   logic               gain_low;    // gain clamps to 1/4
   logic               gain_high;   // gain clamps to 4
   logic               unit_gain;   // flat of 0 or 1
   logic [7:0]         luma_flat_res;
   logic               luma_div;
   dffc_pkg::front_type a_in;
   dffc_pkg::front_type a_ff;

   always_comb begin
      diff_ld = {1'b0, req_live_sample} - {1'b0, req_dark_sample};
      s_pos   = diff_ld[8] ? 8'd0 : diff_ld[7:0];

      // chroma with flat bias
      cdiff  = 10'sd127 + signed'({2'b00, req_live_sample})
                        - signed'({2'b00, req_dark_sample});
      mean_c = (req_plane == dffc_pkg::PLANE_U) ? mean_u_ff : mean_v_ff;
      m_c    = (mean_c == 16'd0) ? dffc_pkg::CHROMA_MID_Q : mean_c;
      bias_raw = signed'({2'b00, req_flat_sample, 8'h00}) - signed'({2'b00, m_c});
      if (bias_raw < -dffc_pkg::BIAS_LIMIT)     bias_cl = -dffc_pkg::BIAS_LIMIT;
      else if (bias_raw > dffc_pkg::BIAS_LIMIT) bias_cl = dffc_pkg::BIAS_LIMIT;
      else                                      bias_cl = bias_raw;
      cv = 20'(signed'({cdiff, 8'h00})) - 20'(bias_cl);
      cr = cv + 20'sd128;
      if (cv[19])              chroma_flat_res = 8'd0;
      else if (|cr[18:16])     chroma_flat_res = 8'hFF;
      else                     chroma_flat_res = cr[15:8];

      // chroma and luma without flat
      if (cdiff[9])            chroma_raw_res = 8'd0;
      else if (cdiff[8])       chroma_raw_res = 8'hFF;
      else                     chroma_raw_res = cdiff[7:0];
      luma_raw_res = diff_ld[8] ? luma_floor_ff : diff_ld[7:0];

      // luma with flat: clamped gain cases resolve here, the rest divide
      unit_gain = (req_flat_sample <= 8'd1);
      gain_low  = (mean_luma_ff < {2'b00, req_flat_sample, 6'b0});
      gain_high = ({2'b00, mean_luma_ff} > {req_flat_sample, 10'b0});
      sq = {1'b0, s_pos} + 9'd2;
      luma_div = 1'b0;
      priority if (unit_gain) luma_flat_res = s_pos;
      else if (gain_low)      luma_flat_res = {1'b0, sq[8:2]};
      else if (gain_high)     luma_flat_res = (|s_pos[7:6]) ? 8'hFF : {s_pos[5:0], 2'b00};
      else begin
         luma_flat_res = 8'd0;
         luma_div      = 1'b1;
      end

      a_in.prod    = s_pos * mean_luma_ff;
      a_in.flat    = req_flat_sample;
      a_in.use_div = 1'b0;
      priority if (mean_luma_ff == 16'd0)             a_in.bypass = req_live_sample;
      else if (mode_ff == dffc_pkg::MODE_DARK)        a_in.bypass = req_dark_sample;
      else if (mode_ff == dffc_pkg::MODE_LIGHT)       a_in.bypass = req_light_sample;
      else if (mode_ff == dffc_pkg::MODE_FLAT)        a_in.bypass = req_flat_sample;
      else if (flat_en_ff) begin
         if (req_plane == dffc_pkg::PLANE_LUMA) begin
            a_in.bypass  = luma_flat_res;
            a_in.use_div = luma_div;
         end else begin
            a_in.bypass  = chroma_flat_res;
         end
      end else begin
         a_in.bypass = (req_plane == dffc_pkg::PLANE_LUMA) ? luma_raw_res : chroma_raw_res;
      end
   end

   // ---------------- numerator and divider stages ----------------
   // quotient = floor((2*s*mean + 256*flat) / (512*flat))
   //          = floor(((s*mean + 128*flat) >> 8) / flat)
   logic [24:0]       nsum;
   dffc_pkg::div_type div_in [1:LAST];
   dffc_pkg::div_type div_ff [1:LAST];

   always_comb begin
      nsum = 25'(a_ff.prod) + 25'({a_ff.flat, 7'b0});
      div_in[1].rem     = nsum[24:8];
      div_in[1].quo     = '0;
      div_in[1].flat    = a_ff.flat;
      div_in[1].bypass  = a_ff.bypass;
      div_in[1].use_div = a_ff.use_div;
      for (int k = 2; k <= LAST; k++) begin
         div_in[k] = dffc_pkg::div_pair(div_ff[k-1],
                        4'(dffc_pkg::QUO_W + 3 - 2 * k));
      end
   end

   always_ff @(posedge clock) begin
      if (adv[0]) a_ff <= a_in;
      for (int k = 1; k <= LAST; k++) begin
         if (adv[k]) div_ff[k] <= div_in[k];
      end
   end

   // ---------------- result ----------------
   assign rsp_out_sample = !div_ff[LAST].use_div ? div_ff[LAST].bypass :
                           (|div_ff[LAST].quo[dffc_pkg::QUO_W-1:8]) ? 8'hFF :
                           div_ff[LAST].quo[7:0];

endmodule

[rtl/core/dffc_checker.sv]
// Port-level checker for the calibration pipeline, bound to the top level.
module dffc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_out_sample
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an empty or draining output lets every stage move, so requests flow
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || !rsp_stall) |-> !req_stall)
      else $error("request stalled while output can move");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> $stable(rsp_out_sample))
      else $error("stalled response changed");

endmodule

bind dark_flat_frame_calibration dffc_checker u_dffc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_out_sample (rsp_out_sample)
);
